/* rtl/velocity_motion_pose_update_defines.svh */
// Assertion macros for the pose update block.
`ifndef VELOCITY_MOTION_POSE_UPDATE_DEFINES_SVH
`define VELOCITY_MOTION_POSE_UPDATE_DEFINES_SVH

// Same-cycle implication, off while reset is high.
`define VMPU_ASSERT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, also checked across reset.
`define VMPU_ASSERT_NEXT(lbl, clk, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/vmpu_pkg.sv */
// Shared types, constants and the arctangent table of the pose update block.
package vmpu_pkg;

  localparam int AW     = 34;  // CORDIC datapath width, Q30
  localparam int RW     = 51;  // angle reduction width
  localparam int NDW    = 64;  // divider numerator width
  localparam int DVW    = 32;  // divisor width

  localparam longint TWO_PI_Q30 = 64'sd6746518852;
  localparam logic signed [AW-1:0] PI_Q30      = 34'sd3373259426;
  localparam logic signed [AW-1:0] TWO_PI_W    = 34'sd6746518852;
  localparam logic signed [AW-1:0] HALF_PI_Q30 = 34'sd1686629713;
  localparam logic signed [AW-1:0] GAIN_Q30    = 34'sd652032874;

  typedef struct packed {
    logic signed [AW-1:0] x;
    logic signed [AW-1:0] y;
    logic signed [AW-1:0] z;
    logic                 neg;
  } cl_t;

  typedef struct packed {
    logic [DVW-1:0] rem;
    logic [NDW-1:0] work;
  } dl_t;

  function automatic logic signed [AW-1:0] atan_q30(input int i);
    logic signed [AW-1:0] v;
    case (i)
      0:  v = 34'sd843314857;
      1:  v = 34'sd497837830;
      2:  v = 34'sd263043837;
      3:  v = 34'sd133525159;
      4:  v = 34'sd67021687;
      5:  v = 34'sd33543516;
      6:  v = 34'sd16775851;
      7:  v = 34'sd8388437;
      8:  v = 34'sd4194283;
      9:  v = 34'sd2097149;
      10: v = 34'sd1048576;
      11: v = 34'sd524288;
      12: v = 34'sd262144;
      13: v = 34'sd131072;
      14: v = 34'sd65536;
      15: v = 34'sd32768;
      16: v = 34'sd16384;
      17: v = 34'sd8192;
      18: v = 34'sd4096;
      19: v = 34'sd2048;
      20: v = 34'sd1024;
      21: v = 34'sd512;
      22: v = 34'sd256;
      23: v = 34'sd128;
      24: v = 34'sd64;
      25: v = 34'sd32;
      26: v = 34'sd16;
      27: v = 34'sd8;
      28: v = 34'sd4;
      29: v = 34'sd2;
      default: v = '0;
    endcase
    return v;
  endfunction

  // Clamp to the signed 32-bit range.
  function automatic logic signed [31:0] sat32(input logic signed [67:0] v);
    logic signed [31:0] r;
    if (v > 68'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (v < -68'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

/* rtl/vmpu_red_cell.sv */
// One restoring step of the angle reduction, for start and end angle.
module vmpu_red_cell
  import vmpu_pkg::*;
#(
  parameter longint PERIOD = 411775,
  parameter int     K      = 0
) (
  input  logic          clk,
  input  logic          en,
  input  logic [RW-1:0] a_in,
  input  logic [RW-1:0] b_in,
  output logic [RW-1:0] a_out,
  output logic [RW-1:0] b_out
);

  localparam logic [RW-1:0] STEP = RW'(PERIOD << K);

  always_ff @(posedge clk) begin
    if (en) begin
      a_out <= (a_in >= STEP) ? a_in - STEP : a_in;
      b_out <= (b_in >= STEP) ? b_in - STEP : b_in;
    end
  end

endmodule

/* rtl/vmpu_cordic_cell.sv */
// One CORDIC rotation stage, for start and end angle.
module vmpu_cordic_cell
  import vmpu_pkg::*;
#(
  parameter int IDX = 0
) (
  input  logic clk,
  input  logic en,
  input  cl_t  a_in,
  input  cl_t  b_in,
  output cl_t  a_out,
  output cl_t  b_out
);

  localparam logic signed [AW-1:0] ANG = atan_q30(IDX);

  function automatic cl_t rot(input cl_t c);
    logic signed [AW-1:0] x;
    logic signed [AW-1:0] y;
    logic signed [AW-1:0] xs;
    logic signed [AW-1:0] ys;
    cl_t r;
    x  = c.x;
    y  = c.y;
    xs = x >>> IDX;
    ys = y >>> IDX;
    r.neg = c.neg;
    if (!c.z[AW-1]) begin
      r.x = x - ys;
      r.y = y + xs;
      r.z = c.z - ANG;
    end else begin
      r.x = x + ys;
      r.y = y - xs;
      r.z = c.z + ANG;
    end
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (en) begin
      a_out <= rot(a_in);
      b_out <= rot(b_in);
    end
  end

endmodule

/* rtl/vmpu_div_cell.sv */
// One restoring division step for the x and y numerators, shared divisor.
module vmpu_div_cell
  import vmpu_pkg::*;
(
  input  logic           clk,
  input  logic           en,
  input  logic [DVW-1:0] d_in,
  input  dl_t            a_in,
  input  dl_t            b_in,
  output logic [DVW-1:0] d_out,
  output dl_t            a_out,
  output dl_t            b_out
);

  function automatic dl_t step(input dl_t c, input logic [DVW-1:0] d);
    logic [DVW:0] trial;
    logic         bit_q;
    dl_t          r;
    trial = {c.rem, c.work[NDW-1]};
    bit_q = (trial >= {1'b0, d});
    r.rem  = bit_q ? DVW'(trial - {1'b0, d}) : trial[DVW-1:0];
    r.work = {c.work[NDW-2:0], bit_q};
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (en) begin
      d_out <= d_in;
      a_out <= step(a_in, d_in);
      b_out <= step(b_in, d_in);
    end
  end

endmodule

/* rtl/velocity_motion_pose_update.sv */
// Pose prediction: velocity motion model, fully pipelined.
//
// Input channel (in_valid / in_stall) takes one request of pose, speed,
// turn rate and step count; the output channel (out_valid / out_stall)
// gives the predicted pose. A request is taken on a rising edge with valid
// high and stall low. One request per cycle is taken back to back while
// the output is not stalled. Between acceptance and out_valid, NRED =
// 51 - clog2(angle period) restoring cells reduce the angles, NC =
// min(CORDIC_STAGES, 30) CORDIC cells form sine and cosine, and 64
// divider cells form the arc quotient. Throughput is one pose per cycle
// while the output is not stalled.
// When the receiver stalls a valid result, the whole pipeline holds and
// in_stall rises in the same cycle; bubbles are kept in place.
// Synchronous reset empties the pipeline and sets straight_limit to 1.
// cfg_wr_en / cfg_wr_data write straight_limit; write only while idle.
module velocity_motion_pose_update
  import vmpu_pkg::*;
#(
  parameter int FRAC_BITS     = 16,
  parameter int CORDIC_STAGES = 18
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_wr_en,
  input  logic [15:0]        cfg_wr_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] pose_x,
  input  logic signed [31:0] pose_y,
  input  logic signed [31:0] pose_heading,
  input  logic signed [31:0] speed,
  input  logic signed [31:0] turn_rate,
  input  logic [15:0]        step_time,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] new_x,
  output logic signed [31:0] new_y,
  output logic signed [31:0] new_heading
);

  localparam int     SH       = 30 - FRAC_BITS;
  localparam longint HALF_LSB = (longint'(1) << SH) >> 1;
  localparam longint PERIOD   = (TWO_PI_Q30 + HALF_LSB) >> SH;
  localparam int     NSH      = 49 - $clog2(PERIOD);
  localparam int     NRED     = NSH + 2;
  localparam logic [RW-1:0] OFFS = RW'(PERIOD << NSH);
  localparam int     NC       = (CORDIC_STAGES < 30) ? CORDIC_STAGES : 30;
  localparam int     NSIDE    = NRED + NC + 3;
  localparam int     NTOT     = NRED + NC + NDW + 10;
  localparam logic signed [65:0] RND = 66'(HALF_LSB);

  typedef struct packed {
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] v;
    logic signed [31:0] w;
    logic [15:0]        t;
    logic               straight;
    logic signed [31:0] heading;
  } side_t;

  typedef struct packed {
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic               straight;
    logic               sx;
    logic               sy;
    logic signed [52:0] dxs;
    logic signed [52:0] dys;
    logic signed [31:0] heading;
  } side2_t;

  logic [15:0]     straight_limit;
  logic [NTOT-1:0] vld;
  logic            adv;

  assign adv       = !(out_valid && out_stall);
  assign in_stall  = !adv;
  assign out_valid = vld[NTOT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      straight_limit <= 16'd1;
    end else if (cfg_wr_en) begin
      straight_limit <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[NTOT-2:0], in_valid};
    end
  end

  // input register
  logic signed [31:0] r0_px, r0_py, r0_ph, r0_v, r0_w;
  logic [15:0]        r0_t;
  logic               r0_straight;
  logic [32:0]        w_mag;

  assign w_mag = turn_rate[31] ? 33'(-34'(turn_rate)) : 33'(turn_rate);

  always_ff @(posedge clk) begin
    if (adv) begin
      r0_px       <= pose_x;
      r0_py       <= pose_y;
      r0_ph       <= pose_heading;
      r0_v        <= speed;
      r0_w        <= turn_rate;
      r0_t        <= step_time;
      r0_straight <= (turn_rate == '0) || (w_mag < {17'd0, straight_limit});
    end
  end

  // turn angle
  logic signed [31:0] r1_px, r1_py, r1_ph, r1_v, r1_w;
  logic [15:0]        r1_t;
  logic               r1_straight;
  logic signed [48:0] r1_turn;

  always_ff @(posedge clk) begin
    if (adv) begin
      r1_px       <= r0_px;
      r1_py       <= r0_py;
      r1_ph       <= r0_ph;
      r1_v        <= r0_v;
      r1_w        <= r0_w;
      r1_t        <= r0_t;
      r1_straight <= r0_straight;
      r1_turn     <= r0_w * $signed({1'b0, r0_t});
    end
  end

  // offset both angles positive, keep their residue
  logic signed [RW-1:0] ph_w, end_w;
  logic [RW-1:0]        red_a [NRED+1];
  logic [RW-1:0]        red_b [NRED+1];
  side_t                side_q [NSIDE];

  assign ph_w  = RW'(r1_ph);
  assign end_w = ph_w + RW'(r1_turn);

  always_ff @(posedge clk) begin
    if (adv) begin
      red_a[0]          <= RW'(ph_w) + OFFS;
      red_b[0]          <= RW'(end_w) + OFFS;
      side_q[0].px       <= r1_px;
      side_q[0].py       <= r1_py;
      side_q[0].v        <= r1_v;
      side_q[0].w        <= r1_w;
      side_q[0].t        <= r1_t;
      side_q[0].straight <= r1_straight;
      side_q[0].heading  <= sat32(68'(end_w));
      for (int k = 1; k < NSIDE; k++) begin
        side_q[k] <= side_q[k-1];
      end
    end
  end

  for (genvar i = 0; i < NRED; i++) begin : g_red
    vmpu_red_cell #(.PERIOD(PERIOD), .K(NRED - 1 - i)) u_cell (
      .clk   (clk),
      .en    (adv),
      .a_in  (red_a[i]),
      .b_in  (red_b[i]),
      .a_out (red_a[i+1]),
      .b_out (red_b[i+1])
    );
  end

  // move to Q30 and fold into the right half plane
  function automatic cl_t fold(input logic [RW-1:0] r);
    logic signed [AW-1:0] z;
    cl_t c;
    z = AW'(r << SH);
    if (z > PI_Q30) begin
      z = z - TWO_PI_W;
    end
    c.neg = 1'b0;
    if (z > HALF_PI_Q30) begin
      z     = z - PI_Q30;
      c.neg = 1'b1;
    end else if (z < -HALF_PI_Q30) begin
      z     = z + PI_Q30;
      c.neg = 1'b1;
    end
    c.x = GAIN_Q30;
    c.y = '0;
    c.z = z;
    return c;
  endfunction

  cl_t cor_a [NC+1];
  cl_t cor_b [NC+1];

  always_ff @(posedge clk) begin
    if (adv) begin
      cor_a[0] <= fold(red_a[NRED]);
      cor_b[0] <= fold(red_b[NRED]);
    end
  end

  for (genvar i = 0; i < NC; i++) begin : g_cor
    vmpu_cordic_cell #(.IDX(i)) u_cell (
      .clk   (clk),
      .en    (adv),
      .a_in  (cor_a[i]),
      .b_in  (cor_b[i]),
      .a_out (cor_a[i+1]),
      .b_out (cor_b[i+1])
    );
  end

  // undo the fold
  logic signed [AW-1:0] sc_s0, sc_c0, sc_s1, sc_c1;

  always_ff @(posedge clk) begin
    if (adv) begin
      sc_s0 <= cor_a[NC].neg ? -cor_a[NC].y : cor_a[NC].y;
      sc_c0 <= cor_a[NC].neg ? -cor_a[NC].x : cor_a[NC].x;
      sc_s1 <= cor_b[NC].neg ? -cor_b[NC].y : cor_b[NC].y;
      sc_c1 <= cor_b[NC].neg ? -cor_b[NC].x : cor_b[NC].x;
    end
  end

  // differences and straight products
  side_t              m1_sd;
  logic signed [AW:0] m1_ds, m1_dc;
  logic signed [65:0] m1_pc, m1_ps;

  always_ff @(posedge clk) begin
    if (adv) begin
      m1_sd <= side_q[NSIDE-1];
      m1_ds <= (AW+1)'(sc_s1) - (AW+1)'(sc_s0);
      m1_dc <= (AW+1)'(sc_c0) - (AW+1)'(sc_c1);
      m1_pc <= side_q[NSIDE-1].v * sc_c0;
      m1_ps <= side_q[NSIDE-1].v * sc_s0;
    end
  end

  // arc numerators, straight steps rounded to the output format
  side_t              m2_sd;
  logic signed [66:0] m2_nx, m2_ny;
  logic signed [35:0] m2_pcr, m2_psr;
  logic signed [65:0] pc_rnd, ps_rnd;

  assign pc_rnd = (m1_pc + 66'sd536870912) >>> 30;
  assign ps_rnd = (m1_ps + 66'sd536870912) >>> 30;

  always_ff @(posedge clk) begin
    if (adv) begin
      m2_sd  <= m1_sd;
      m2_nx  <= m1_sd.v * m1_ds;
      m2_ny  <= m1_sd.v * m1_dc;
      m2_pcr <= pc_rnd[35:0];
      m2_psr <= ps_rnd[35:0];
    end
  end

  // magnitudes into the divider, straight steps times step count
  logic [66:0]    nx_abs, ny_abs;
  logic [32:0]    wd_abs;
  logic [DVW-1:0] div_d [NDW+1];
  dl_t            div_a [NDW+1];
  dl_t            div_b [NDW+1];
  side2_t         side2_q [NDW+1];

  assign nx_abs = m2_nx[66] ? 67'(-m2_nx) : 67'(m2_nx);
  assign ny_abs = m2_ny[66] ? 67'(-m2_ny) : 67'(m2_ny);
  assign wd_abs = m2_sd.w[31] ? 33'(-34'(m2_sd.w)) : 33'(m2_sd.w);

  always_ff @(posedge clk) begin
    if (adv) begin
      div_d[0]            <= wd_abs[DVW-1:0];
      div_a[0].rem        <= '0;
      div_a[0].work       <= nx_abs[NDW-1:0];
      div_b[0].rem        <= '0;
      div_b[0].work       <= ny_abs[NDW-1:0];
      side2_q[0].px       <= m2_sd.px;
      side2_q[0].py       <= m2_sd.py;
      side2_q[0].straight <= m2_sd.straight;
      side2_q[0].sx       <= m2_nx[66] ^ m2_sd.w[31];
      side2_q[0].sy       <= m2_ny[66] ^ m2_sd.w[31];
      side2_q[0].dxs      <= m2_pcr * $signed({1'b0, m2_sd.t});
      side2_q[0].dys      <= m2_psr * $signed({1'b0, m2_sd.t});
      side2_q[0].heading  <= m2_sd.heading;
      for (int k = 1; k <= NDW; k++) begin
        side2_q[k] <= side2_q[k-1];
      end
    end
  end

  for (genvar i = 0; i < NDW; i++) begin : g_div
    vmpu_div_cell u_cell (
      .clk   (clk),
      .en    (adv),
      .d_in  (div_d[i]),
      .a_in  (div_a[i]),
      .b_in  (div_b[i]),
      .d_out (div_d[i+1]),
      .a_out (div_a[i+1]),
      .b_out (div_b[i+1])
    );
  end

  // signed quotient, rounded to the output format, path select
  side2_t             qs;
  logic signed [65:0] qx, qy, arc_x, arc_y;
  logic signed [67:0] q_dx, q_dy;
  logic signed [31:0] q_px, q_py, q_heading;

  assign qs    = side2_q[NDW];
  assign qx    = qs.sx ? -$signed({2'b00, div_a[NDW].work}) : $signed({2'b00, div_a[NDW].work});
  assign qy    = qs.sy ? -$signed({2'b00, div_b[NDW].work}) : $signed({2'b00, div_b[NDW].work});
  assign arc_x = (qx + RND) >>> SH;
  assign arc_y = (qy + RND) >>> SH;

  always_ff @(posedge clk) begin
    if (adv) begin
      q_dx      <= qs.straight ? 68'(qs.dxs) : 68'(arc_x);
      q_dy      <= qs.straight ? 68'(qs.dys) : 68'(arc_y);
      q_px      <= qs.px;
      q_py      <= qs.py;
      q_heading <= qs.heading;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (adv) begin
      new_x       <= sat32(68'(q_px) + q_dx);
      new_y       <= sat32(68'(q_py) + q_dy);
      new_heading <= q_heading;
    end
  end

endmodule

/* rtl/vmpu_checker.sv */
// Port-level checks for the pose update block, bound to the top level.
`include "velocity_motion_pose_update_defines.svh"

module vmpu_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic signed [31:0] new_x,
  input logic signed [31:0] new_y,
  input logic signed [31:0] new_heading
);

  // hold a stalled result
  `VMPU_ASSERT_NEXT(a_out_hold, clk, !rst && out_valid && out_stall, out_valid && $stable(new_x) && $stable(new_y) && $stable(new_heading), "stalled result changed")

  // back pressure comes only from a stalled result
  `VMPU_ASSERT(a_stall_src, clk, rst, in_stall, out_valid && out_stall, "input stalled without output stall")

  // reset drops every request in flight
  `VMPU_ASSERT_NEXT(a_rst_clear, clk, rst, !out_valid && !in_stall, "pipeline not empty after reset")

endmodule

bind velocity_motion_pose_update vmpu_checker u_vmpu_checker (.*);
